// File: src/rrsc_pkg.sv
// rrsc_pkg: types and constants shared by the redundant relay status checker
// no dependencies; imported by the request and config interfaces and every module of the block

package rrsc_pkg;

	// item kinds carried in req_type
	typedef enum logic [1:0] {
		REQ_WR_MAIN  = 2'd0,
		REQ_WR_STBY  = 2'd1,
		REQ_WR_ENTRY = 2'd2,
		REQ_CHECK    = 2'd3
	} req_kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_LINK_A = 2'd0,
		CFG_LINK_B = 2'd1
	} cfg_reg_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	localparam int BYTE_IDX_W = 6;
	localparam int CHAN_W     = 7;
	localparam int GROUP_W    = 2;

	localparam int DC_SPLIT_CHANNEL = 96;
	localparam int DC_LOW_BYTES     = 12;
	localparam int DC_HIGH_BYTES    = 4;
	localparam int DC_FLAG_BYTES    = DC_LOW_BYTES + DC_HIGH_BYTES;
	localparam int DC_IDX_W         = $clog2(DC_FLAG_BYTES);

	localparam int GROUP_STRIDE = 12;
	localparam int GROUP_OFFSET = 4;

	typedef struct packed {
		logic [CHAN_W-1:0] cch;
		logic              common;
		logic              unit;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{cch: '0, common: 1'b1, unit: 1'b1};

	// dc detection: any nonzero byte in the low or the high range
	typedef struct packed {
		logic lo;
		logic hi;
	} dc_flags_t;

	// everything the vote needs for one check
	typedef struct packed {
		logic group0;
		logic unchecked;
		logic has_common;
		logic expect_on;
		logic m;
		logic s;
		logic mc;
		logic sc;
		logic main_dc;
		logic stby_dc;
		logic link_a;
		logic link_b;
	} chk_t;

endpackage

// File: src/rrsc_ifs.sv
// valid/ready channel interfaces of the relay status checker
// depends on rrsc_pkg for field widths

interface rrsc_req_if import rrsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [BYTE_IDX_W-1:0] byte_index;
	logic [7:0]            byte_value;
	logic                  entry_has_unit;
	logic                  entry_has_common;
	logic [CHAN_W-1:0]     common_channel;
	logic [GROUP_W-1:0]    dip_group;
	logic [CHAN_W-1:0]     channel;
	logic                  expected_on;
	logic                  last_dip;

	modport source (
		output valid, req_type, byte_index, byte_value, entry_has_unit,
		       entry_has_common, common_channel, dip_group, channel,
		       expected_on, last_dip,
		input  ready
	);
	modport sink (
		input  valid, req_type, byte_index, byte_value, entry_has_unit,
		       entry_has_common, common_channel, dip_group, channel,
		       expected_on, last_dip,
		output ready
	);
endinterface

interface rrsc_res_if ();
	logic valid;
	logic ready;
	logic dip_ok;
	logic all_ok;
	logic list_done;

	modport source (output valid, dip_ok, all_ok, list_done, input ready);
	modport sink (input valid, dip_ok, all_ok, list_done, output ready);
endinterface

interface rrsc_cfg_if import rrsc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// File: src/rrsc_status_mem.sv
// one status snapshot: byte memory with two registered read ports,
// per-byte valid bits and nonzero flags for the dc test; uses rrsc_pkg

module rrsc_status_mem import rrsc_pkg::*; #(
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic [7:0]    rd_data_a,
	output logic [7:0]    rd_data_b,
	output dc_flags_t     dc
);

	logic [7:0]               mem [DEPTH];
	logic [DEPTH-1:0]         vld_q;
	logic [DC_FLAG_BYTES-1:0] nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			nz_q  <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
			if (wr_addr < AW'(DC_FLAG_BYTES))
				nz_q[wr_addr[DC_IDX_W-1:0]] <= |wr_data;
		end
	end

	// bytes never written read as zero
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rd_data_a <= vld_q[rd_addr_a] ? mem[rd_addr_a] : 8'd0;
			rd_data_b <= vld_q[rd_addr_b] ? mem[rd_addr_b] : 8'd0;
		end
	end

	assign dc.lo = |nz_q[DC_LOW_BYTES-1:0];
	assign dc.hi = |nz_q[DC_FLAG_BYTES-1:DC_LOW_BYTES];

endmodule

// File: src/rrsc_table.sv
// channel table: entry memory with one registered read port and
// per-entry valid bits; unwritten entries read as the reset entry; uses rrsc_pkg

module rrsc_table import rrsc_pkg::*; #(
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_entry,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_entry
);

	entry_t           mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (wr_en)
			vld_q[wr_addr] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_entry;
		if (rd_en)
			rd_entry <= vld_q[rd_addr] ? mem[rd_addr] : ENTRY_RESET;
	end

endmodule

// File: src/rrsc_vote.sv
// pass/fail decision for one dip: tmr or dmr vote for group 0,
// direct bit compare for the other groups; uses rrsc_pkg

module rrsc_vote import rrsc_pkg::*; (
	input  chk_t chk,
	output logic dip_ok
);

	logic tmr_dec;
	logic tmr_on;
	logic dmr_ok;

	always_comb begin
		tmr_dec = 1'b0;
		tmr_on  = 1'b0;
		if (chk.link_a && chk.link_b) begin
			if (chk.m == chk.s) begin
				tmr_dec = 1'b1;
				tmr_on  = chk.m;
			end else if (chk.mc == chk.sc) begin
				tmr_dec = 1'b1;
				tmr_on  = chk.mc;
			end else if (chk.m == chk.mc && chk.s == chk.sc) begin
				// dc-dc test: trust the side whose partner shows no dc
				if ((!chk.stby_dc && chk.m) || (!chk.main_dc && chk.s)) begin
					tmr_dec = 1'b1;
					tmr_on  = 1'b1;
				end
			end
		end else if (chk.link_a) begin
			tmr_dec = chk.m == chk.mc;
			tmr_on  = chk.m;
		end else if (chk.link_b) begin
			tmr_dec = chk.s == chk.sc;
			tmr_on  = chk.s;
		end
	end

	always_comb begin
		if (chk.link_a && chk.link_b)
			dmr_ok = (chk.m | chk.s) == chk.expect_on;
		else if (chk.link_a)
			dmr_ok = chk.m == chk.expect_on;
		else if (chk.link_b)
			dmr_ok = chk.s == chk.expect_on;
		else
			dmr_ok = 1'b0;
	end

	always_comb begin
		if (!chk.group0)
			dip_ok = chk.m == chk.expect_on;
		else if (chk.unchecked)
			dip_ok = 1'b1;
		else if (chk.has_common)
			dip_ok = tmr_dec && (tmr_on == chk.expect_on);
		else
			dip_ok = dmr_ok;
	end

endmodule

// File: src/redundant_relay_status_checker.sv
// Redundant relay status checker, top level. A check item's result is registered
// through the table read at the transfer, the snapshot read and the vote register.
// Throughput: one item per cycle; the pipeline holds only while a result waits.
// Reset clears all valid bits, dc flags, link settings and the running AND at
// once; no clearing pass, the block takes items right after reset.
// Uses rrsc_pkg, the rrsc interfaces, rrsc_status_mem, rrsc_table, rrsc_vote.

module redundant_relay_status_checker import rrsc_pkg::*; #(
	parameter int STATUS_BYTES = 64,
	parameter int CHANNELS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	rrsc_req_if.sink  req,
	rrsc_res_if.source res,
	rrsc_cfg_if.sink  cfg
);

	localparam int SB_AW = $clog2(STATUS_BYTES);
	localparam int TB_AW = $clog2(CHANNELS);

	logic adv;
	logic accept;
	logic link_a_q;
	logic link_b_q;

	// stage 1
	logic                  vld_s1;
	req_kind_t             kind_s1;
	logic [BYTE_IDX_W-1:0] bidx_s1;
	logic [7:0]            bval_s1;
	logic [GROUP_W-1:0]    grp_s1;
	logic [CHAN_W-1:0]     ch_s1;
	logic                  exp_s1;
	logic                  last_s1;
	logic                  ch_ok_s1;
	entry_t                ent_s1;

	// stage 2
	logic                  vld_s2;
	req_kind_t             kind_s2;
	logic                  grp0_s2;
	logic [CHAN_W-1:0]     ch_s2;
	logic [CHAN_W-1:0]     cch_s2;
	logic                  exp_s2;
	logic                  last_s2;
	logic                  ch_ok_s2;
	logic                  unit_s2;
	logic                  common_s2;
	logic                  main_dc_s2;
	logic                  stby_dc_s2;

	// result register
	logic res_valid_q;
	logic dip_ok_q;
	logic all_ok_q;
	logic list_done_q;
	logic running_ok_q;

	logic                  tbl_wr_en;
	entry_t                tbl_wr_entry;
	logic                  bidx_ok;
	logic                  main_wr_en;
	logic                  stby_wr_en;
	logic [BYTE_IDX_W-1:0] dir_idx;
	logic [SB_AW-1:0]      main_addr_a;
	logic [SB_AW-1:0]      ch_addr;
	logic [SB_AW-1:0]      cch_addr;
	logic [7:0]            main_rd_a;
	logic [7:0]            main_rd_b;
	logic [7:0]            stby_rd_a;
	logic [7:0]            stby_rd_b;
	dc_flags_t             main_dc;
	dc_flags_t             stby_dc;
	logic                  low_range;
	chk_t                  chk;
	logic                  dip_ok;
	logic                  ok_all;
	logic                  is_check_s2;

	assign adv    = !res_valid_q || res.ready;
	assign accept = req.valid && adv;
	assign req.ready = adv;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_a_q <= 1'b0;
			link_b_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				CFG_LINK_A: link_a_q <= cfg.wr_data[0];
				CFG_LINK_B: link_b_q <= cfg.wr_data[0];
				default: ;
			endcase
		end
	end

	// channel table, written and read at transfer
	assign tbl_wr_en = accept && req_kind_t'(req.req_type) == REQ_WR_ENTRY &&
		int'(req.channel) < CHANNELS;
	assign tbl_wr_entry = '{cch: req.common_channel, common: req.entry_has_common,
		unit: req.entry_has_unit};

	rrsc_table #(.DEPTH(CHANNELS)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (tbl_wr_en),
		.wr_addr  (TB_AW'(req.channel)),
		.wr_entry (tbl_wr_entry),
		.rd_en    (adv),
		.rd_addr  (TB_AW'(req.channel)),
		.rd_entry (ent_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (adv)
			vld_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= req_kind_t'(req.req_type);
			bidx_s1  <= req.byte_index;
			bval_s1  <= req.byte_value;
			grp_s1   <= req.dip_group;
			ch_s1    <= req.channel;
			exp_s1   <= req.expected_on;
			last_s1  <= req.last_dip;
			ch_ok_s1 <= int'(req.channel) < CHANNELS;
		end
	end

	// snapshots, written and read as the item leaves stage 1
	assign bidx_ok    = int'(bidx_s1) < STATUS_BYTES;
	assign main_wr_en = adv && vld_s1 && kind_s1 == REQ_WR_MAIN && bidx_ok;
	assign stby_wr_en = adv && vld_s1 && kind_s1 == REQ_WR_STBY && bidx_ok;

	// direct groups read main byte stride*group + channel/8 + offset
	assign dir_idx = BYTE_IDX_W'(GROUP_STRIDE * int'(grp_s1) + int'(ch_s1[CHAN_W-1:3]) +
		GROUP_OFFSET);
	assign ch_addr     = SB_AW'(ch_s1[CHAN_W-1:3]);
	assign cch_addr    = SB_AW'(ent_s1.cch[CHAN_W-1:3]);
	assign main_addr_a = (grp_s1 == '0) ? ch_addr : SB_AW'(dir_idx);

	rrsc_status_mem #(.DEPTH(STATUS_BYTES)) u_main (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (main_wr_en),
		.wr_addr   (SB_AW'(bidx_s1)),
		.wr_data   (bval_s1),
		.rd_en     (adv),
		.rd_addr_a (main_addr_a),
		.rd_addr_b (cch_addr),
		.rd_data_a (main_rd_a),
		.rd_data_b (main_rd_b),
		.dc        (main_dc)
	);

	rrsc_status_mem #(.DEPTH(STATUS_BYTES)) u_stby (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (stby_wr_en),
		.wr_addr   (SB_AW'(bidx_s1)),
		.wr_data   (bval_s1),
		.rd_en     (adv),
		.rd_addr_a (ch_addr),
		.rd_addr_b (cch_addr),
		.rd_data_a (stby_rd_a),
		.rd_data_b (stby_rd_b),
		.dc        (stby_dc)
	);

	assign low_range = ch_s1 < CHAN_W'(DC_SPLIT_CHANNEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (adv)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2    <= kind_s1;
			grp0_s2    <= grp_s1 == '0;
			ch_s2      <= ch_s1;
			cch_s2     <= ent_s1.cch;
			exp_s2     <= exp_s1;
			last_s2    <= last_s1;
			ch_ok_s2   <= ch_ok_s1;
			unit_s2    <= ent_s1.unit;
			common_s2  <= ent_s1.common;
			// dc state as seen by this check, before later writes land
			main_dc_s2 <= low_range ? main_dc.lo : main_dc.hi;
			stby_dc_s2 <= low_range ? stby_dc.lo : stby_dc.hi;
		end
	end

	// vote
	assign chk = '{
		group0:     grp0_s2,
		unchecked:  !ch_ok_s2 || !unit_s2,
		has_common: common_s2,
		expect_on:  exp_s2,
		m:          main_rd_a[ch_s2[2:0]],
		s:          stby_rd_a[ch_s2[2:0]],
		mc:         main_rd_b[cch_s2[2:0]],
		sc:         stby_rd_b[cch_s2[2:0]],
		main_dc:    main_dc_s2,
		stby_dc:    stby_dc_s2,
		link_a:     link_a_q,
		link_b:     link_b_q
	};

	rrsc_vote u_vote (
		.chk    (chk),
		.dip_ok (dip_ok)
	);

	assign is_check_s2 = vld_s2 && kind_s2 == REQ_CHECK;
	assign ok_all      = running_ok_q && dip_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			running_ok_q <= 1'b1;
		end else if (adv) begin
			res_valid_q <= is_check_s2;
			if (is_check_s2)
				running_ok_q <= last_s2 ? 1'b1 : ok_all;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dip_ok_q    <= dip_ok;
			all_ok_q    <= ok_all;
			list_done_q <= last_s2;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.dip_ok    = dip_ok_q;
	assign res.all_ok    = all_ok_q;
	assign res.list_done = list_done_q;

`ifndef NO_ASSERTIONS
	// running and starts over after the last dip of a list
	a_list_restart: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_check_s2 && last_s2 |=> running_ok_q)
		else $error("running and not restored after last dip");

	// the running and can never pass while this dip failed
	a_all_implies_dip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!all_ok_q || dip_ok_q))
		else $error("all_ok set on a failed dip");

	// write items leave the pipeline without a result
	a_no_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s2 && kind_s2 != REQ_CHECK |=> !res_valid_q)
		else $error("result produced by a write item");
`endif

endmodule
